// File: hdl/xfbp_pkg.sv
package xfbp_pkg;

   localparam int WORD_W     = 64;
   localparam int HEADER_W   = 11;
   localparam int HLEN_W     = 4;
   localparam int PLEN_W     = 7;
   localparam int COUNT_W    = 7;
   localparam int LEAD_W     = 5;
   localparam int CODE_W     = 3;

   // two-bit case codes that open every header after the first
   localparam logic [1:0] CASE_REUSE = 2'b00;
   localparam logic [1:0] CASE_ZERO  = 2'b01;
   localparam logic [1:0] CASE_SHORT = 2'b10;
   localparam logic [1:0] CASE_LONG  = 2'b11;

   localparam logic [HLEN_W-1:0] HLEN_FIRST = 4'd7;
   localparam logic [HLEN_W-1:0] HLEN_CASE  = 4'd2;
   localparam logic [HLEN_W-1:0] HLEN_SHORT = 4'd9;
   localparam logic [HLEN_W-1:0] HLEN_LONG  = 4'd11;

   localparam logic [COUNT_W-1:0] SHORT_CENTRE_MAX = 7'd16;
   localparam logic [COUNT_W-1:0] WORD_BITS        = 7'd64;
   localparam logic [COUNT_W-1:0] WORD_TOP_BIT     = 7'd63;

   // "no window" marks; the leading mark never equals a rounded count
   localparam logic [LEAD_W-1:0]  NO_WINDOW_LEAD  = 5'd31;
   localparam logic [COUNT_W-1:0] NO_WINDOW_TRAIL = 7'd127;

   localparam logic [LEAD_W-1:0] LEAD_ROUND_TABLE [8] =
      '{5'd0, 5'd8, 5'd12, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24};

   typedef struct packed {
      logic [HEADER_W-1:0] header_bits;
      logic [HLEN_W-1:0]   header_length;
      logic [WORD_W-1:0]   payload_bits;
      logic [PLEN_W-1:0]   payload_length;
   } xfbp_result_type;

   // trailing zeros; 64 for a zero word
   function automatic logic [COUNT_W-1:0] ctz64(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] low;
      logic [COUNT_W-2:0] idx;
      low = v & (~v + 64'd1);
      idx = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (low[i]) idx = idx | 6'(i);
      end
      return (v == '0) ? WORD_BITS : {1'b0, idx};
   endfunction

   function automatic logic [COUNT_W-1:0] clz64(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] rev;
      for (int i = 0; i < WORD_W; i++) begin
         rev[i] = v[WORD_W-1-i];
      end
      return ctz64(rev);
   endfunction

   function automatic logic [CODE_W-1:0] lead_code(input logic [COUNT_W-1:0] lz);
      logic [CODE_W-1:0] code;
      case (lz) inside
         [7'd0:7'd7]:   code = 3'd0;
         [7'd8:7'd11]:  code = 3'd1;
         [7'd12:7'd15]: code = 3'd2;
         [7'd16:7'd23]: code = 3'd3 + {1'b0, lz[2:1]};
         default:       code = 3'd7;
      endcase
      return code;
   endfunction

endpackage

// File: hdl/xfbp_channels.sv
interface xfbp_req_if import xfbp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] raw_value;

   modport source (output valid, output raw_value, input ready);
   modport sink   (input valid, input raw_value, output ready);
endinterface

interface xfbp_rsp_if import xfbp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [HEADER_W-1:0] header_bits;
   logic [HLEN_W-1:0]   header_length;
   logic [WORD_W-1:0]   payload_bits;
   logic [PLEN_W-1:0]   payload_length;

   modport source (output valid, output header_bits, output header_length,
                   output payload_bits, output payload_length, input ready);
   modport sink   (input valid, input header_bits, input header_length,
                   input payload_bits, input payload_length, output ready);
endinterface

// File: hdl/xfbp_encoder.sv
module xfbp_encoder import xfbp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [WORD_W-1:0] raw_value,
   output xfbp_result_type   result
);

   logic               is_first_ff, is_first_in;
   logic [WORD_W-1:0]  previous_ff, previous_in;
   logic [LEAD_W-1:0]  win_lead_ff, win_lead_in;
   logic [COUNT_W-1:0] win_trail_ff, win_trail_in;

   logic [WORD_W-1:0]  x;
   logic [COUNT_W-1:0] tz_x, lz_x, tz_v, centre, shift_amt;
   logic [CODE_W-1:0]  code;
   logic [LEAD_W-1:0]  rlz;
   logic               hit;

   always_comb begin
      x         = previous_ff ^ raw_value;
      tz_x      = ctz64(x);
      lz_x      = clz64(x);
      tz_v      = ctz64(raw_value);
      code      = lead_code(lz_x);
      rlz       = LEAD_ROUND_TABLE[code];
      hit       = (rlz == win_lead_ff) && (tz_x >= win_trail_ff);
      centre    = WORD_BITS - {2'b00, rlz} - tz_x;
      shift_amt = tz_x + 7'd1;

      is_first_in  = is_first_ff;
      previous_in  = previous_ff;
      win_lead_in  = win_lead_ff;
      win_trail_in = win_trail_ff;
      result       = '0;

      if (is_first_ff) begin
         is_first_in          = 1'b0;
         previous_in          = raw_value;
         result.header_bits   = {4'b0000, tz_v};
         result.header_length = HLEN_FIRST;
         if (tz_v != WORD_BITS) begin
            result.payload_bits   = raw_value >> (tz_v + 7'd1);
            result.payload_length = WORD_TOP_BIT - tz_v;
         end
      end else if (x == '0) begin
         result.header_bits   = {9'd0, CASE_ZERO};
         result.header_length = HLEN_CASE;
      end else begin
         previous_in = raw_value;
         if (hit) begin
            result.header_bits    = {9'd0, CASE_REUSE};
            result.header_length  = HLEN_CASE;
            result.payload_bits   = x >> win_trail_ff;
            result.payload_length = WORD_BITS - {2'b00, win_lead_ff} - win_trail_ff;
         end else begin
            win_lead_in  = rlz;
            win_trail_in = tz_x;
            if (centre <= SHORT_CENTRE_MAX) begin
               result.header_bits   = {2'b00, CASE_SHORT, code, centre[3:0]};
               result.header_length = HLEN_SHORT;
            end else begin
               result.header_bits   = {CASE_LONG, code, centre[5:0]};
               result.header_length = HLEN_LONG;
            end
            // lowest centre bit is always 1 and is dropped
            result.payload_bits   = x >> shift_amt;
            result.payload_length = centre - 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         is_first_ff  <= 1'b1;
         previous_ff  <= '0;
         win_lead_ff  <= NO_WINDOW_LEAD;
         win_trail_ff <= NO_WINDOW_TRAIL;
      end else if (step) begin
         is_first_ff  <= is_first_in;
         previous_ff  <= previous_in;
         win_lead_ff  <= win_lead_in;
         win_trail_ff <= win_trail_in;
      end
   end

endmodule

// File: hdl/xor_float_bit_packer_core.sv
// XOR bit packer: one 64-bit double pattern in per item, one code word out per
// item (header of 7, 2, 9 or 11 bits plus a payload of 0 to 64 bits, both right
// aligned). Items are taken one per clock cycle with no gaps while the output is
// not stalled; each one passes an input register, then the XOR, zero-count and
// window logic, then the result register, which presents the result so it can be
// taken at the following edge when the output is not stalled. The XOR state is
// updated as each item leaves the input register, so back-to-back items see the
// state of the one before. Both stages stall together when the result is not
// taken; the input side still takes an item while its register is empty. The
// first item after reset is coded as a leading value; to end a stream send
// 0x7ff8000000000000 as an ordinary item.
module xor_float_bit_packer_core import xfbp_pkg::*; (
   input logic          clock,
   input logic          reset,
   xfbp_req_if.sink     req_chan,
   xfbp_rsp_if.source   rsp_chan
);

   logic              s1_valid_ff, s1_valid_in;
   logic [WORD_W-1:0] s1_value_ff, s1_value_in;
   logic              out_valid_ff, out_valid_in;
   xfbp_result_type   out_result_ff, out_result_in;
   xfbp_result_type   enc_result;

   logic out_free, advance, accept;

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign accept         = req_chan.valid && req_chan.ready;

   xfbp_encoder u_encoder (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .raw_value (s1_value_ff),
      .result    (enc_result)
   );

   always_comb begin
      s1_valid_in   = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      s1_value_in   = accept ? req_chan.raw_value : s1_value_ff;
      out_valid_in  = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
      out_result_in = advance ? enc_result : out_result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_value_ff   <= s1_value_in;
      out_result_ff <= out_result_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.header_bits    = out_result_ff.header_bits;
   assign rsp_chan.header_length  = out_result_ff.header_length;
   assign rsp_chan.payload_bits   = out_result_ff.payload_bits;
   assign rsp_chan.payload_length = out_result_ff.payload_length;

   a_hlen_legal: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_result_ff.header_length == HLEN_FIRST ||
                        out_result_ff.header_length == HLEN_CASE ||
                        out_result_ff.header_length == HLEN_SHORT ||
                        out_result_ff.header_length == HLEN_LONG))
      else $error("illegal header length");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_result_ff.payload_length == WORD_BITS ||
         (out_result_ff.payload_bits >> out_result_ff.payload_length) == '0))
      else $error("payload bits above payload length");

   a_zero_no_payload: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_result_ff.header_length == HLEN_CASE &&
       out_result_ff.header_bits[1:0] == CASE_ZERO)
      |-> out_result_ff.payload_length == '0)
      else $error("zero-XOR item carries payload");

   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("item lost between stages");

endmodule
